FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define BDH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("bdh assertion failed");

// Antecedent this cycle implies consequent next cycle.
`define BDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bdh assertion failed");

`endif

FILE: rtl/bdh_pkg.sv
`default_nettype none

package bdh_pkg;

  localparam int unsigned KEY_WIDTH = 3;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] POLL_WINDOW_RST = CFG_W'(250);
  localparam logic [CFG_W-1:0] JITTER_LIMIT_RST = CFG_W'(150);
  localparam logic [CFG_W-1:0] HOLD_LIMIT_RST  = CFG_W'(900);
  localparam logic [CFG_W-1:0] INACTIVE_RST    = CFG_W'(200);

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_POLL = 2'd1,
    MODE_LOCK = 2'd2,
    MODE_IACT = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_HOLD = 2'd1,
    EV_UP   = 2'd2,
    EV_HLUP = 2'd3
  } event_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_WINDOW  = 2'd0,
    CFG_JITTER_LIMIT = 2'd1,
    CFG_HOLD_LIMIT   = 2'd2,
    CFG_INACTIVE     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] poll_window_ms;
    logic [CFG_W-1:0] jitter_limit_ms;
    logic [CFG_W-1:0] hold_limit_ms;
    logic [CFG_W-1:0] inactive_ms;
  } cfg_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key_sample;
    logic [TIME_W-1:0]    now_ms;
  } in_item_t;

  typedef struct packed {
    logic                 event_valid;
    event_kind_e          event_kind;
    logic [KEY_WIDTH-1:0] event_keys;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/bdh_in_if.sv
`default_nettype none

interface bdh_in_if;
  import bdh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_WIDTH-1:0] key_sample;
  logic [TIME_W-1:0]    now_ms;

  modport source (output valid, key_sample, now_ms, input ready);
  modport sink   (input valid, key_sample, now_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/bdh_out_if.sv
`default_nettype none

interface bdh_out_if;
  import bdh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 event_valid;
  logic [1:0]           event_kind;
  logic [KEY_WIDTH-1:0] event_keys;

  modport source (output valid, event_valid, event_kind, event_keys, input ready);
  modport sink   (input valid, event_valid, event_kind, event_keys, output ready);
endinterface

`default_nettype wire

FILE: rtl/bdh_cfg_regs.sv
`default_nettype none

module bdh_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bdh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bdh_pkg::CFG_W-1:0]      cfg_wdata_i,
  output bdh_pkg::cfg_t                       cfg_o
);
  import bdh_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLL_WINDOW:  cfg_d.poll_window_ms  = cfg_wdata_i;
        CFG_JITTER_LIMIT: cfg_d.jitter_limit_ms = cfg_wdata_i;
        CFG_HOLD_LIMIT:   cfg_d.hold_limit_ms   = cfg_wdata_i;
        CFG_INACTIVE:     cfg_d.inactive_ms     = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_window_ms  <= POLL_WINDOW_RST;
      cfg_q.jitter_limit_ms <= JITTER_LIMIT_RST;
      cfg_q.hold_limit_ms   <= HOLD_LIMIT_RST;
      cfg_q.inactive_ms     <= INACTIVE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/bdh_core.sv
`default_nettype none

module bdh_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire bdh_pkg::in_item_t item_i,
  input  wire bdh_pkg::cfg_t     cfg_i,
  output bdh_pkg::out_item_t result_o
);
  import bdh_pkg::*;

  mode_e                mode_q, mode_d;
  logic [KEY_WIDTH-1:0] gathered_q, gathered_d;
  logic [KEY_WIDTH-1:0] locked_q, locked_d;
  logic                 hold_q, hold_d;
  logic [TIME_W-1:0]    mark_q, mark_d;
  logic [TIME_W-1:0]    match_q, match_d;

  logic [KEY_WIDTH-1:0] gathered;
  logic [TIME_W-1:0]    since_mark;
  logic [TIME_W-1:0]    since_match;
  logic [3:0]           sel;

  assign gathered    = gathered_q | item_i.key_sample;
  assign since_mark  = item_i.now_ms - mark_q;
  assign since_match = item_i.now_ms - match_q;
  assign sel = {hold_q,
                since_mark  > TIME_W'(cfg_i.hold_limit_ms),
                since_match > TIME_W'(cfg_i.jitter_limit_ms),
                locked_q != gathered};

  always_comb begin
    mode_d     = mode_q;
    gathered_d = gathered;
    locked_d   = locked_q;
    hold_d     = hold_q;
    mark_d     = mark_q;
    match_d    = match_q;
    result_o   = '0;

    case (mode_q)
      MODE_WAIT: begin
        if (gathered != '0) begin
          mark_d = item_i.now_ms;
          mode_d = MODE_POLL;
        end
      end
      MODE_POLL: begin
        if (since_mark > TIME_W'(cfg_i.poll_window_ms)) begin
          locked_d             = gathered;
          gathered_d           = '0;
          mode_d               = MODE_LOCK;
          mark_d               = item_i.now_ms;
          match_d              = item_i.now_ms;
          result_o.event_valid = 1'b1;
          result_o.event_kind  = EV_DOWN;
          result_o.event_keys  = gathered;
        end
      end
      MODE_LOCK: begin
        gathered_d = '0;
        case (sel) inside
          4'h5, 4'h6, 4'h9: begin
            match_d              = item_i.now_ms;
            hold_d               = 1'b1;
            result_o.event_valid = 1'b1;
            result_o.event_kind  = EV_HOLD;
            result_o.event_keys  = locked_q;
          end
          4'h4: begin
            hold_d               = 1'b1;
            result_o.event_valid = 1'b1;
            result_o.event_kind  = EV_HOLD;
            result_o.event_keys  = locked_q;
          end
          4'h0, 4'h2, 4'h8, 4'hA, 4'hC, 4'hE: begin
            match_d = item_i.now_ms;
          end
          4'h3: begin
            result_o.event_valid = 1'b1;
            result_o.event_kind  = EV_UP;
            result_o.event_keys  = locked_q;
            mode_d               = MODE_IACT;
            mark_d               = item_i.now_ms;
          end
          4'h7, 4'hB, 4'hF: begin
            result_o.event_valid = 1'b1;
            result_o.event_kind  = EV_HLUP;
            result_o.event_keys  = locked_q;
            mode_d               = MODE_IACT;
            mark_d               = item_i.now_ms;
          end
          default: begin
            // mismatch inside the jitter window: keep waiting
          end
        endcase
      end
      default: begin
        gathered_d = '0;
        locked_d   = '0;
        hold_d     = 1'b0;
        if (since_mark > TIME_W'(cfg_i.inactive_ms)) begin
          mode_d = MODE_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_WAIT;
      gathered_q <= '0;
      locked_q   <= '0;
      hold_q     <= 1'b0;
      mark_q     <= '0;
      match_q    <= '0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      gathered_q <= gathered_d;
      locked_q   <= locked_d;
      hold_q     <= hold_d;
      mark_q     <= mark_d;
      match_q    <= match_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/button_debounce_hold_detector_unit.sv
// Channel  Dir  Payload                               Handshake
// in_i     in   key_sample[2:0], now_ms[31:0]         valid/ready
// out_o    out  event_valid, event_kind[1:0],         valid/ready
//               event_keys[2:0]
// cfg      in   cfg_idx_i[1:0], cfg_wdata_i[15:0]     cfg_we_i, no back-pressure
//
// One poll per cycle sustained while out_o keeps accepting results.
// Input register, then the mode update and result register, set the timing.
// Reset (rst_ni, async, active low) returns to wait mode and default limits.
// A stalled result holds the output register; the input register still takes
// one more transaction, after which in_i.ready drops until the output drains.
`default_nettype none

`include "assert_macros.svh"

module button_debounce_hold_detector_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  bdh_in_if.sink                             in_i,
  bdh_out_if.source                          out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bdh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bdh_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import bdh_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item_q;
  logic      s1_valid_q, s1_valid_d;
  out_item_t result;
  out_item_t out_item_q;
  logic      out_valid_q, out_valid_d;
  logic      advance;
  logic      in_accept;
  logic      step;

  // output register free or being drained this cycle
  assign advance   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;
  assign step      = s1_valid_q && advance;

  bdh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdh_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.key_sample <= in_i.key_sample;
      s1_item_q.now_ms     <= in_i.now_ms;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_valid = out_item_q.event_valid;
  assign out_o.event_kind  = out_item_q.event_kind;
  assign out_o.event_keys  = out_item_q.event_keys;

  // both stages full and output stalled: no room for another transaction
  `BDH_ASSERT(a_full_blocks_input, clk_i, rst_ni, !(out_valid_q && !out_o.ready && s1_valid_q) || !in_i.ready)
  // an accepted transaction occupies the input register next cycle
  `BDH_ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, in_accept, s1_valid_q)
  // a result without an event carries all-zero fields
  `BDH_ASSERT(a_quiet_result_zero, clk_i, rst_ni, !(out_o.valid && !out_o.event_valid) || (out_o.event_kind == EV_DOWN && out_o.event_keys == '0))

endmodule

`default_nettype wire
